### hdl/crc32_pkg.sv
// ----------------------------------------------------------------------------
// crc32_pkg
// Shared types, constants and CRC update functions for the CRC-32 engine.
// ----------------------------------------------------------------------------
package crc32_pkg;

   localparam int unsigned CrcWidth  = 32;
   localparam int unsigned ByteWidth = 8;
   localparam int unsigned CsrIdxW   = 2;

   localparam logic [CrcWidth-1:0] PolyReflected = 32'hEDB8_8320;
   localparam logic [CrcWidth-1:0] PolyNormal    = 32'h04C1_1DB7;
   localparam logic [CrcWidth-1:0] AllOnes       = 32'hFFFF_FFFF;
   localparam logic [CrcWidth-1:0] TopBit        = 32'h8000_0000;

   localparam logic [CsrIdxW-1:0] CSR_REFLECTED_MODE = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_INIT_ONES      = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_INVERT_OUTPUT  = 2'd2;
   localparam logic [CsrIdxW-1:0] CSR_REVERSE_OUTPUT = 2'd3;

   typedef struct packed {
      logic reflected_mode;
      logic init_ones;
      logic invert_output;
      logic reverse_output;
   } cfg_type;

   typedef struct packed {
      logic                load;
      logic [CrcWidth-1:0] start;
   } reload_type;

   function automatic logic [CrcWidth-1:0] start_value(input logic init_ones);
      return init_ones ? AllOnes : '0;
   endfunction

   function automatic logic [CrcWidth-1:0] fold_lsb_first(
      input logic [CrcWidth-1:0]  rem,
      input logic [ByteWidth-1:0] data
   );
      logic [CrcWidth-1:0] r;
      r = rem ^ {{(CrcWidth-ByteWidth){1'b0}}, data};
      for (int k = 0; k < ByteWidth; k++) begin
         r = r[0] ? ((r >> 1) ^ PolyReflected) : (r >> 1);
      end
      return r;
   endfunction

   function automatic logic [CrcWidth-1:0] fold_msb_first(
      input logic [CrcWidth-1:0]  rem,
      input logic [ByteWidth-1:0] data
   );
      logic [CrcWidth-1:0] r;
      r = rem ^ {data, {(CrcWidth-ByteWidth){1'b0}}};
      for (int k = 0; k < ByteWidth; k++) begin
         r = ((r & TopBit) != '0) ? ((r << 1) ^ PolyNormal) : (r << 1);
      end
      return r;
   endfunction

   function automatic logic [CrcWidth-1:0] bit_reverse(input logic [CrcWidth-1:0] v);
      logic [CrcWidth-1:0] acc;
      for (int k = 0; k < CrcWidth; k++) begin
         acc[CrcWidth-1-k] = v[k];
      end
      return acc;
   endfunction

   function automatic logic [CrcWidth-1:0] finish(
      input logic [CrcWidth-1:0] rem,
      input cfg_type             cfg
   );
      logic [CrcWidth-1:0] r;
      r = cfg.reverse_output ? bit_reverse(rem) : rem;
      if (cfg.invert_output) begin
         r = r ^ AllOnes;
      end
      return r;
   endfunction

endpackage

### hdl/crc32_csr.sv
// ----------------------------------------------------------------------------
// crc32_csr
// Configuration registers; requests a remainder reload on every write.
// ----------------------------------------------------------------------------
module crc32_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [crc32_pkg::CsrIdxW-1:0]     csr_index,
   input  logic                              csr_wdata,
   output crc32_pkg::cfg_type                cfg,
   output crc32_pkg::reload_type             reload
);

   crc32_pkg::cfg_type cfg_ff;
   crc32_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            crc32_pkg::CSR_REFLECTED_MODE: cfg_in.reflected_mode = csr_wdata;
            crc32_pkg::CSR_INIT_ONES:      cfg_in.init_ones      = csr_wdata;
            crc32_pkg::CSR_INVERT_OUTPUT:  cfg_in.invert_output  = csr_wdata;
            crc32_pkg::CSR_REVERSE_OUTPUT: cfg_in.reverse_output = csr_wdata;
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reflected_mode <= 1'b1;
         cfg_ff.init_ones      <= 1'b1;
         cfg_ff.invert_output  <= 1'b1;
         cfg_ff.reverse_output <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg          = cfg_ff;
   assign reload.load  = csr_write;
   assign reload.start = crc32_pkg::start_value(cfg_in.init_ones);

endmodule

### hdl/crc32_core.sv
// ----------------------------------------------------------------------------
// crc32_core
// Input register, byte fold into the running remainder, result register.
// ----------------------------------------------------------------------------
module crc32_core (
   input  logic                                clock,
   input  logic                                reset,
   input  crc32_pkg::cfg_type                  cfg,
   input  crc32_pkg::reload_type               reload,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [crc32_pkg::ByteWidth-1:0]     req_data_byte,
   input  logic                                req_byte_present,
   input  logic                                req_last_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [crc32_pkg::CrcWidth-1:0]      rsp_crc_value
);

   logic                               s1_valid_ff, s1_valid_in;
   logic [crc32_pkg::ByteWidth-1:0]    s1_byte_ff, s1_byte_in;
   logic                               s1_present_ff, s1_present_in;
   logic                               s1_last_ff, s1_last_in;
   logic [crc32_pkg::CrcWidth-1:0]     rem_ff, rem_in;
   logic                               out_valid_ff, out_valid_in;
   logic [crc32_pkg::CrcWidth-1:0]     out_crc_ff, out_crc_in;

   logic                               out_free;
   logic                               s1_fire;
   logic                               req_take;
   logic [crc32_pkg::CrcWidth-1:0]     folded;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign s1_fire   = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_stall = s1_valid_ff && !s1_fire;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      if (!s1_present_ff) begin
         folded = rem_ff;
      end else if (cfg.reflected_mode) begin
         folded = crc32_pkg::fold_lsb_first(rem_ff, s1_byte_ff);
      end else begin
         folded = crc32_pkg::fold_msb_first(rem_ff, s1_byte_ff);
      end
   end

   always_comb begin
      // advance input stage
      s1_valid_in   = req_take ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
      s1_byte_in    = req_take ? req_data_byte    : s1_byte_ff;
      s1_present_in = req_take ? req_byte_present : s1_present_ff;
      s1_last_in    = req_take ? req_last_byte    : s1_last_ff;

      // update remainder
      rem_in = rem_ff;
      if (reload.load) begin
         rem_in = reload.start;
      end else if (s1_fire) begin
         rem_in = s1_last_ff ? crc32_pkg::start_value(cfg.init_ones) : folded;
      end

      // load result register
      out_valid_in = out_valid_ff && rsp_stall;
      out_crc_in   = out_crc_ff;
      if (s1_fire && s1_last_ff) begin
         out_valid_in = 1'b1;
         out_crc_in   = crc32_pkg::finish(folded, cfg);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         rem_ff       <= crc32_pkg::AllOnes;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         rem_ff       <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_byte_ff    <= s1_byte_in;
      s1_present_ff <= s1_present_in;
      s1_last_ff    <= s1_last_in;
      out_crc_ff    <= out_crc_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_crc_value = out_crc_ff;

endmodule

### hdl/crc32_configurable_byte_engine.sv
// A last-marked transaction passes the input register, then the result register once that is free.
// Throughput: one transaction per cycle; the byte fold into the running remainder
// is one 8-step shift/XOR network between the input and result registers. The input
// stalls only while a last-marked transaction waits behind a held result.
// Reset (synchronous, active high): reflected mode, start value all ones,
// inverted output, no reversal; remainder all ones, pipeline and result empty.
// ----------------------------------------------------------------------------
// crc32_configurable_byte_engine
// Byte-serial CRC-32 with selectable bit order, start value and output finish.
// ----------------------------------------------------------------------------
module crc32_configurable_byte_engine (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [crc32_pkg::CsrIdxW-1:0]       csr_index,
   input  logic                                csr_wdata,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [crc32_pkg::ByteWidth-1:0]     req_data_byte,
   input  logic                                req_byte_present,
   input  logic                                req_last_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [crc32_pkg::CrcWidth-1:0]      rsp_crc_value
);

   crc32_pkg::cfg_type    cfg;
   crc32_pkg::reload_type reload;

   crc32_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .reload    (reload)
   );

   crc32_core u_core (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .reload           (reload),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_byte_present (req_byte_present),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_crc_value    (rsp_crc_value)
   );

endmodule

### hdl/crc32_checker.sv
// ----------------------------------------------------------------------------
// crc32_checker
// Port-level checks on the CRC-32 engine, bound to the top level.
// ----------------------------------------------------------------------------
module crc32_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic                               req_last_byte,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [crc32_pkg::CrcWidth-1:0]     rsp_crc_value
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_crc_value))
      else $error("stalled result changed or dropped");

   // drop the result register on reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a new result comes from an earlier accepted last-marked transaction
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_last_byte, 2))
      else $error("result without a last-marked transaction");

   // no back-pressure while the result register is empty
   a_no_stall_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty result register");

endmodule

bind crc32_configurable_byte_engine crc32_checker u_crc32_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_last_byte (req_last_byte),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_crc_value (rsp_crc_value)
);

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-32 byte engine testbench
// Drives message bytes with random gaps and result stalls, predicts every CRC
// from the register settings in a scoreboard, and checks each result in order.
// ----------------------------------------------------------------------------
module testbench;
   import crc32_pkg::*;

   localparam int CycleLimit   = 400000;
   localparam int RandomItems  = 1300;
   localparam int PipeSettle   = 4;

   class crc_scoreboard;
      cfg_type             cfg;
      logic [CrcWidth-1:0] remainder;
      logic [CrcWidth-1:0] expected_crcs[$];
      int unsigned         mismatches;
      int unsigned         crcs_checked;
      int unsigned         transactions;

      function new();
         cfg.reflected_mode = 1'b1;
         cfg.init_ones      = 1'b1;
         cfg.invert_output  = 1'b1;
         cfg.reverse_output = 1'b0;
         remainder          = seed_value();
         mismatches         = 0;
         crcs_checked       = 0;
         transactions       = 0;
      endfunction

      function logic [CrcWidth-1:0] seed_value();
         return cfg.init_ones ? AllOnes : '0;
      endfunction

      function logic [CrcWidth-1:0] shift_in_reflected(logic [CrcWidth-1:0] r,
                                                        logic [ByteWidth-1:0] b);
         r = r ^ {24'b0, b};
         repeat (ByteWidth) r = r[0] ? ((r >> 1) ^ PolyReflected) : (r >> 1);
         return r;
      endfunction

      function logic [CrcWidth-1:0] shift_in_normal(logic [CrcWidth-1:0] r,
                                                     logic [ByteWidth-1:0] b);
         r = r ^ {b, 24'b0};
         repeat (ByteWidth) r = r[CrcWidth-1] ? ((r << 1) ^ PolyNormal) : (r << 1);
         return r;
      endfunction

      function logic [CrcWidth-1:0] finalize(logic [CrcWidth-1:0] r);
         logic [CrcWidth-1:0] m;
         for (int k = 0; k < CrcWidth; k++) m[k] = r[CrcWidth-1-k];
         if (cfg.reverse_output) r = m;
         if (cfg.invert_output) r = r ^ AllOnes;
         return r;
      endfunction

      // Any register write drops the message in progress.
      function void write_reg(logic [CsrIdxW-1:0] idx, logic value);
         case (idx)
            CSR_REFLECTED_MODE: cfg.reflected_mode = value;
            CSR_INIT_ONES:      cfg.init_ones      = value;
            CSR_INVERT_OUTPUT:  cfg.invert_output  = value;
            CSR_REVERSE_OUTPUT: cfg.reverse_output = value;
            default: ;
         endcase
         remainder = seed_value();
      endfunction

      function void note_transaction(logic [ByteWidth-1:0] data, logic present, logic last);
         if (present || last) transactions++;
         if (present)
            remainder = cfg.reflected_mode ? shift_in_reflected(remainder, data)
                                           : shift_in_normal(remainder, data);
         if (last) begin
            expected_crcs.push_back(finalize(remainder));
            remainder = seed_value();
         end
      endfunction

      function void check_crc(logic [CrcWidth-1:0] actual);
         logic [CrcWidth-1:0] want;
         if (expected_crcs.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected crc %08h, expected none", $time, actual);
            return;
         end
         want = expected_crcs.pop_front();
         crcs_checked++;
         if (actual !== want) begin
            mismatches++;
            $display("%0t: crc mismatch: expected %08h, actual %08h", $time, want, actual);
         end
      endfunction

      function int pending();
         return expected_crcs.size();
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 csr_write;
   logic [CsrIdxW-1:0]   csr_index;
   logic                 csr_wdata;
   logic                 req_valid;
   logic                 req_stall;
   logic [ByteWidth-1:0] req_data_byte;
   logic                 req_byte_present;
   logic                 req_last_byte;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [CrcWidth-1:0]  rsp_crc_value;

   crc_scoreboard crc_sb;
   bit            calm;
   int            hold_off_cycles;
   int            items_sent;
   int            settings_applied;
   int            cycle_count;

   crc32_configurable_byte_engine u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_byte_present (req_byte_present),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_crc_value    (rsp_crc_value)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial cycle_count = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Sample both channels and register writes at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write) crc_sb.write_reg(csr_index, csr_wdata);
         if (req_valid && !req_stall)
            crc_sb.note_transaction(req_data_byte, req_byte_present, req_last_byte);
         if (rsp_valid && !rsp_stall) crc_sb.check_crc(rsp_crc_value);
      end
   end

   // Result receiver: random stall per result, one long hold on request.
   initial begin
      int gap;
      int n;
      rsp_stall = 1'b1;
      wait (reset === 1'b0);
      forever begin
         if (hold_off_cycles > 0) begin
            n = hold_off_cycles;
            hold_off_cycles = 0;
            repeat (n) @(negedge clock) rsp_stall <= 1'b1;
         end
         gap = calm ? 0 : $urandom_range(0, 16);
         repeat (gap) @(negedge clock) rsp_stall <= 1'b1;
         @(negedge clock) rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_item(input logic [ByteWidth-1:0] data, input logic present,
                            input logic last);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 16);
      repeat (gap) @(negedge clock) req_valid <= 1'b0;
      @(negedge clock);
      req_valid        <= 1'b1;
      req_data_byte    <= data;
      req_byte_present <= present;
      req_last_byte    <= last;
      do @(posedge clock); while (req_stall);
      if (present || last) items_sent++;
   endtask

   task automatic wait_idle();
      @(negedge clock) req_valid <= 1'b0;
      while (crc_sb.pending() != 0) @(posedge clock);
      repeat (PipeSettle) @(posedge clock);
   endtask

   task automatic csr_put(input logic [CsrIdxW-1:0] idx, input logic value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock) csr_write <= 1'b0;
   endtask

   task automatic apply_settings(input logic rm, input logic io, input logic inv,
                                 input logic rev);
      wait_idle();
      csr_put(CSR_REFLECTED_MODE, rm);
      csr_put(CSR_INIT_ONES, io);
      csr_put(CSR_INVERT_OUTPUT, inv);
      csr_put(CSR_REVERSE_OUTPUT, rev);
      settings_applied++;
   endtask

   task automatic send_random_message();
      int n;
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 6);
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
         send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
      end
      if ($urandom_range(0, 3) == 0) send_item(8'($urandom), 1'b0, 1'b1);
      else send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
   endtask

   initial begin
      int phase;
      int target;
      crc_sb           = new();
      calm             = 1'b0;
      hold_off_cycles  = 0;
      items_sent       = 0;
      settings_applied = 0;
      reset            = 1'b1;
      csr_write        = 1'b0;
      csr_index        = CSR_REFLECTED_MODE;
      csr_wdata        = 1'b0;
      req_valid        = 1'b0;
      req_data_byte    = '0;
      req_byte_present = 1'b0;
      req_last_byte    = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Reset settings: single bytes, empty end, idle item inside a message.
      send_item(8'h00, 1'b1, 1'b1);
      send_item(8'hFF, 1'b1, 1'b1);
      send_item(8'h5C, 1'b0, 1'b1);
      send_item(8'h31, 1'b1, 1'b0);
      send_item(8'h7E, 1'b0, 1'b0);
      send_item(8'h32, 1'b1, 1'b1);
      send_item(8'h80, 1'b1, 1'b0);
      send_item(8'h01, 1'b1, 1'b0);
      send_item(8'hAA, 1'b0, 1'b1);

      // Register write in the middle of a message drops it.
      send_item(8'hA5, 1'b1, 1'b0);
      send_item(8'h5A, 1'b1, 1'b0);
      wait_idle();
      csr_put(CSR_REFLECTED_MODE, 1'b0);
      send_item(8'h3C, 1'b1, 1'b1);

      apply_settings(1'b0, 1'b0, 1'b0, 1'b0);
      send_item(8'h00, 1'b1, 1'b1);
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'hFF, 1'b1, 1'b1);
      send_item(8'h01, 1'b1, 1'b0);
      send_item(8'h80, 1'b1, 1'b1);

      apply_settings(1'b1, 1'b1, 1'b1, 1'b1);
      send_item(8'hFF, 1'b1, 1'b0);
      send_item(8'h00, 1'b1, 1'b1);
      send_item(8'h00, 1'b0, 1'b1);

      apply_settings(1'b0, 1'b1, 1'b1, 1'b1);
      send_item(8'hA5, 1'b1, 1'b1);
      send_item(8'hFF, 1'b1, 1'b0);
      send_item(8'h00, 1'b1, 1'b1);

      target = items_sent + RandomItems;
      phase  = 0;
      while (items_sent < target) begin
         if (phase == 0) apply_settings(1'b0, 1'b0, 1'b0, 1'b0);
         else if (phase == 1) apply_settings(1'b1, 1'b1, 1'b1, 1'b1);
         else apply_settings(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
         calm = ($urandom_range(0, 3) == 0);
         if (phase == 3) begin
            // Hold results back while single-byte messages keep coming.
            calm = 1'b1;
            hold_off_cycles = 300;
            repeat (40) send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
         end
         repeat ($urandom_range(10, 30)) send_random_message();
         if ($urandom_range(0, 1) == 0)
            repeat ($urandom_range(1, 3)) send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
         phase++;
      end

      wait_idle();
      repeat (PipeSettle) @(posedge clock);
      $display("Sent %0d transactions under %0d register settings in both bit orders;",
               crc_sb.transactions, settings_applied);
      $display("checked %0d CRCs with random gaps, stalls and one long result hold.",
               crc_sb.crcs_checked);
      if (crc_sb.mismatches == 0 && crc_sb.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
